/* sv/htpm_pkg.sv */
package htpm_pkg;

  localparam int HUE_BITS_DEF = 16;
  localparam int CH_W         = 8;
  localparam int DIV_W        = 11;
  localparam int REM_W        = DIV_W + 1;
  localparam int NUM_W        = 13;
  localparam int HUE_OUT_W    = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CH_W-1:0] CFG_RESET = 8'd222;

  localparam int LANES    = 3;
  localparam int LANE_PIX = 0;
  localparam int LANE_REF = 1;
  localparam int LANE_OBJ = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_BLUE  = 3'd0,
    REG_REF_GREEN = 3'd1,
    REG_REF_RED   = 3'd2,
    REG_OBJ_BLUE  = 3'd3,
    REG_OBJ_GREEN = 3'd4,
    REG_OBJ_RED   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] pixel_blue;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_red;
  } pix_in_t;

  typedef struct packed {
    logic                 mask_on;
    logic [HUE_OUT_W-1:0] pixel_hue;
  } pix_out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
  } div_lane_t;

endpackage

/* sv/htpm_prep.sv */
module htpm_prep
  import htpm_pkg::*;
(
  input  logic [CH_W-1:0] blue,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] red,
  output div_lane_t       lane
);

  logic [CH_W-1:0]         mx;
  logic [CH_W-1:0]         mn;
  logic [CH_W-1:0]         s;
  logic [DIV_W-1:0]        six_s;
  logic signed [NUM_W-1:0] s_x;
  logic signed [NUM_W-1:0] r_x;
  logic signed [NUM_W-1:0] g_x;
  logic signed [NUM_W-1:0] b_x;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] num_fix;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    s = mx - mn;
    six_s = DIV_W'({s, 2'b00}) + DIV_W'({s, 1'b0});
    s_x = signed'({{(NUM_W-CH_W){1'b0}}, s});
    r_x = signed'({{(NUM_W-CH_W){1'b0}}, red});
    g_x = signed'({{(NUM_W-CH_W){1'b0}}, green});
    b_x = signed'({{(NUM_W-CH_W){1'b0}}, blue});
    // red wins ties, then green
    if (red == mx) begin
      num = g_x - b_x;
    end else if (green == mx) begin
      num = (s_x <<< 1) + b_x - r_x;
    end else begin
      num = (s_x <<< 2) + r_x - g_x;
    end
    if (num < 0) begin
      num_fix = num + (s_x <<< 2) + (s_x <<< 1);
    end else begin
      num_fix = num;
    end
    // grey: zero over one gives hue 0
    if (s == '0) begin
      lane.rem = '0;
      lane.dvs = DIV_W'(1);
    end else begin
      lane.rem = num_fix[REM_W-1:0];
      lane.dvs = six_s;
    end
  end

endmodule

/* sv/htpm_cell.sv */
module htpm_cell
  import htpm_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            valid_in,
  input  div_lane_t [LANES-1:0]           lane_in,
  input  logic [LANES-1:0][HUE_BITS-1:0]  quo_in,
  output logic                            valid_out,
  output div_lane_t [LANES-1:0]           lane_out,
  output logic [LANES-1:0][HUE_BITS-1:0]  quo_out
);

  div_lane_t [LANES-1:0]          lane_next;
  logic [LANES-1:0][HUE_BITS-1:0] quo_next;
  logic [LANES-1:0][REM_W-1:0]    sh;
  logic [LANES-1:0]               ge;

  // one restoring division step per lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sh[i] = {lane_in[i].rem[REM_W-2:0], 1'b0};
      ge[i] = sh[i] >= {1'b0, lane_in[i].dvs};
      lane_next[i].dvs = lane_in[i].dvs;
      lane_next[i].rem = ge[i] ? (sh[i] - {1'b0, lane_in[i].dvs}) : sh[i];
      quo_next[i] = {quo_in[i][HUE_BITS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_out <= lane_next;
      quo_out  <= quo_next;
    end
  end

endmodule

/* sv/hue_threshold_pixel_mask_core.sv */
// Hue threshold pixel mask. Each pixel's HSV hue, as a HUE_BITS fraction of a turn,
// comes out of a chain of HUE_BITS divider cells, one quotient bit per cell; the
// hues of the reference and object colours ride along in the same cells, and one
// final stage forms their mean as threshold and sets the mask. One pixel is accepted
// every cycle unless every stage is full and the output is stalled; empty stages
// fill up while the output is stalled. Colour writes apply to every pixel accepted
// after the write. pixel_hue holds the low 16 bits of the hue. cfg_ready is always
// high; register indexes above five are ignored.
module hue_threshold_pixel_mask_core
  import htpm_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pix_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]      cfg_data
);

  logic [CH_W-1:0] ref_blue;
  logic [CH_W-1:0] ref_green;
  logic [CH_W-1:0] ref_red;
  logic [CH_W-1:0] obj_blue;
  logic [CH_W-1:0] obj_green;
  logic [CH_W-1:0] obj_red;

  div_lane_t [LANES-1:0]          st_lane [HUE_BITS+1];
  logic [LANES-1:0][HUE_BITS-1:0] st_quo  [HUE_BITS+1];
  logic                           st_v    [HUE_BITS+1];
  logic                           rdy     [HUE_BITS+1];

  logic [HUE_BITS-1:0]           h_pix;
  logic [HUE_BITS-1:0]           h_ref;
  logic [HUE_BITS-1:0]           h_obj;
  logic [HUE_BITS:0]             h_sum;
  logic [HUE_BITS-1:0]           thr;
  logic                          on;
  logic [HUE_BITS+HUE_OUT_W-1:0] hue_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_blue  <= CFG_RESET;
      ref_green <= CFG_RESET;
      ref_red   <= CFG_RESET;
      obj_blue  <= CFG_RESET;
      obj_green <= CFG_RESET;
      obj_red   <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_BLUE:  ref_blue  <= cfg_data;
        REG_REF_GREEN: ref_green <= cfg_data;
        REG_REF_RED:   ref_red   <= cfg_data;
        REG_OBJ_BLUE:  obj_blue  <= cfg_data;
        REG_OBJ_GREEN: obj_green <= cfg_data;
        REG_OBJ_RED:   obj_red   <= cfg_data;
        default: ;
      endcase
    end
  end

  htpm_prep u_prep_pix (
    .blue  (in_data.pixel_blue),
    .green (in_data.pixel_green),
    .red   (in_data.pixel_red),
    .lane  (st_lane[0][LANE_PIX])
  );

  htpm_prep u_prep_ref (
    .blue  (ref_blue),
    .green (ref_green),
    .red   (ref_red),
    .lane  (st_lane[0][LANE_REF])
  );

  htpm_prep u_prep_obj (
    .blue  (obj_blue),
    .green (obj_green),
    .red   (obj_red),
    .lane  (st_lane[0][LANE_OBJ])
  );

  assign st_v[0]   = in_valid;
  assign st_quo[0] = '0;

  // ready ripples back through empty stages
  assign rdy[HUE_BITS] = !out_valid || !out_stall;
  assign in_stall      = !rdy[0];

  for (genvar k = 0; k < HUE_BITS; k++) begin : g_chain
    assign rdy[k] = !st_v[k+1] || rdy[k+1];

    htpm_cell #(
      .HUE_BITS (HUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (rdy[k]),
      .valid_in  (st_v[k]),
      .lane_in   (st_lane[k]),
      .quo_in    (st_quo[k]),
      .valid_out (st_v[k+1]),
      .lane_out  (st_lane[k+1]),
      .quo_out   (st_quo[k+1])
    );
  end

  always_comb begin
    h_pix   = st_quo[HUE_BITS][LANE_PIX];
    h_ref   = st_quo[HUE_BITS][LANE_REF];
    h_obj   = st_quo[HUE_BITS][LANE_OBJ];
    h_sum   = {1'b0, h_ref} + {1'b0, h_obj};
    thr     = h_sum[HUE_BITS:1];
    on      = (h_ref < h_obj) ? (h_pix >= thr) : (h_pix <= thr);
    hue_ext = {{HUE_OUT_W{1'b0}}, h_pix};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[HUE_BITS]) begin
      out_valid <= st_v[HUE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[HUE_BITS]) begin
      out_data.mask_on   <= on;
      out_data.pixel_hue <= hue_ext[HUE_OUT_W-1:0];
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import htpm_pkg::*;

  localparam int HUE_W          = HUE_BITS_DEF;
  localparam int PIPE_LATENCY   = HUE_W + 1;
  localparam int SETTLE_CYCLES  = PIPE_LATENCY + 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PIXELS_PER_SET = 175;
  localparam int EXP_IDX_W      = 6;
  localparam int EXP_DEPTH      = 1 << EXP_IDX_W;

  // indexes past the last colour register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  pix_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  pix_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CH_W-1:0]      cfg_data;

  logic [CH_W-1:0] colour_regs [0:5];
  pix_out_t        expected_fifo [EXP_DEPTH];
  int unsigned     exp_wr;
  int unsigned     exp_rd;
  int unsigned     mismatch_count;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycle_count;

  hue_threshold_pixel_mask_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned hue_turn_frac(logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                                                    logic [CH_W-1:0] r);
    longint cmax;
    longint cmin;
    longint span;
    longint num;
    cmax = r;
    if (g > cmax) cmax = g;
    if (b > cmax) cmax = b;
    cmin = r;
    if (g < cmin) cmin = g;
    if (b < cmin) cmin = b;
    span = cmax - cmin;
    if (span == 0) return 0;
    if (r == cmax) num = longint'(g) - longint'(b);
    else if (g == cmax) num = 2 * span + longint'(b) - longint'(r);
    else num = 4 * span + longint'(r) - longint'(g);
    if (num < 0) num += 6 * span;
    return (num << HUE_W) / (6 * span);
  endfunction

  function automatic pix_out_t predict_mask_result(pix_in_t px);
    longint unsigned ref_hue;
    longint unsigned obj_hue;
    longint unsigned thresh;
    longint unsigned hue;
    pix_out_t res;
    ref_hue = hue_turn_frac(colour_regs[REG_REF_BLUE], colour_regs[REG_REF_GREEN],
                            colour_regs[REG_REF_RED]);
    obj_hue = hue_turn_frac(colour_regs[REG_OBJ_BLUE], colour_regs[REG_OBJ_GREEN],
                            colour_regs[REG_OBJ_RED]);
    thresh  = (ref_hue + obj_hue) >> 1;
    hue     = hue_turn_frac(px.pixel_blue, px.pixel_green, px.pixel_red);
    res.mask_on   = (ref_hue < obj_hue) ? (hue >= thresh) : (hue <= thresh);
    res.pixel_hue = hue[HUE_OUT_W-1:0];
    return res;
  endfunction

  // expectations stored on input beats, compared on output beats, same process
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_fifo[exp_wr[EXP_IDX_W-1:0]] = predict_mask_result(in_data);
        exp_wr++;
      end
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result beat, expected none, got mask %0b hue %0d",
                   $time, out_data.mask_on, out_data.pixel_hue);
          mismatch_count++;
        end else begin
          want = expected_fifo[exp_rd[EXP_IDX_W-1:0]];
          exp_rd++;
          if (out_data.mask_on !== want.mask_on) begin
            $display("%0t: mask_on mismatch, expected %0b, got %0b (hue %0d)",
                     $time, want.mask_on, out_data.mask_on, want.pixel_hue);
            mismatch_count++;
          end
          if (out_data.pixel_hue !== want.pixel_hue) begin
            $display("%0t: pixel_hue mismatch, expected %0d, got %0d",
                     $time, want.pixel_hue, out_data.pixel_hue);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pixel(input pix_in_t px);
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_OBJ_RED) colour_regs[idx] = val;
  endtask

  task automatic set_colours(input pix_in_t ref_px, input pix_in_t obj_px, input bit spare);
    write_reg(REG_REF_BLUE, ref_px.pixel_blue);
    write_reg(REG_REF_GREEN, ref_px.pixel_green);
    write_reg(REG_REF_RED, ref_px.pixel_red);
    write_reg(REG_OBJ_BLUE, obj_px.pixel_blue);
    write_reg(REG_OBJ_GREEN, obj_px.pixel_green);
    write_reg(REG_OBJ_RED, obj_px.pixel_red);
    if (spare) begin
      write_reg(CFG_IDX_SPARE_A, 8'h5a);
      write_reg(CFG_IDX_SPARE_B, 8'ha5);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel(bit extreme);
    if (extreme) return $urandom_range(1) ? 8'hff : 8'h00;
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    logic [CH_W-1:0] v;
    px = {CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
    v  = CH_W'($urandom_range(255));
    case ($urandom_range(15))
      0: px = '{v, v, v};
      1: px.pixel_green = px.pixel_red;
      2: px.pixel_blue = px.pixel_green;
      3: px.pixel_blue = px.pixel_red;
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_reset_colours();
    pix_in_t cases [12];
    cases = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd255},
              '{8'd0, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd0}, '{8'd255, 8'd0, 8'd255},
              '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd0}, '{8'd1, 8'd0, 8'd255},
              '{8'd0, 8'd1, 8'd255}, '{8'd128, 8'd128, 8'd128}, '{8'd200, 8'd17, 8'd93}};
    foreach (cases[i]) send_pixel(cases[i]);
    drain_results();
  endtask

  task automatic test_colour_registers();
    pix_in_t probes [3];
    probes = '{'{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd0}};
    // reference hue below object hue
    set_colours('{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd0}, 1'b0);
    foreach (probes[i]) send_pixel(probes[i]);
    drain_results();
    // reference hue above object hue, spare indexes must not disturb anything
    set_colours('{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd255}, 1'b1);
    foreach (probes[i]) send_pixel(probes[i]);
    drain_results();
    // both colours grey at the extremes
    set_colours('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 1'b1);
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd7, 8'd7, 8'd7});
    drain_results();
  endtask

  task automatic test_random_pixels(input int unsigned snd_pct, input int unsigned rcv_pct);
    pix_in_t ref_px;
    pix_in_t obj_px;
    send_idle_pct = snd_pct;
    stall_pct     = rcv_pct;
    for (int s = 0; s < 2; s++) begin
      ref_px = '{pick_channel(s == 0), pick_channel(s == 0), pick_channel(s == 0)};
      obj_px = '{pick_channel(s == 0), pick_channel(s == 0), pick_channel(s == 0)};
      set_colours(ref_px, obj_px, 1'($urandom_range(1)));
      repeat (PIXELS_PER_SET) send_pixel(random_pixel());
      drain_results();
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    in_data        <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    out_stall      <= 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    exp_wr         = 0;
    exp_rd         = 0;
    foreach (colour_regs[i]) colour_regs[i] = CFG_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_colours();
    test_colour_registers();
    test_random_pixels(27, 75);
    test_random_pixels(75, 27);
    test_random_pixels(0, 0);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
